@@ rtl/pwma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pwma_pkg;

  localparam int WIDTH_W = 16;
  localparam int SUM_W = 20;
  localparam int MASS_W = 15;

  localparam int WINDOW_DEFAULT = 10;
  localparam int FIFO_DEPTH_DEFAULT = 16;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd8000;

  // mass = avg * MASS_NUM / MASS_DEN via reciprocal multiply and one correction
  localparam int SCALED_W = 30;
  localparam int RECIP_W = 31;
  localparam int MASS_SHIFT = 45;
  localparam int MASS_PROD_W = SCALED_W + RECIP_W;
  localparam logic [13:0] MASS_NUM = 14'd10000;
  localparam logic [14:0] MASS_DEN = 15'd21178;
  localparam logic [RECIP_W-1:0] MASS_RECIP = RECIP_W'((64'd1 << MASS_SHIFT) / 64'd21178);

  typedef struct packed {
    logic               accepted;
    logic [WIDTH_W-1:0] last_width;
    logic               averaging;
    logic               avg_on;
  } meta_t;

  typedef struct packed {
    logic               accepted;
    logic [WIDTH_W-1:0] last_width;
    logic [WIDTH_W-1:0] average_width;
    logic               averaging;
    logic [MASS_W-1:0]  mass_grams;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/pwma_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pwma_fifo
  import pwma_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output      logic    pop_valid,
  output      result_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  result_t              entries [DEPTH];
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [CNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_LAST) ? '0 : head + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign pop_valid = (count != '0);
  assign pop_data  = entries[head];

endmodule

`default_nettype wire

@@ rtl/pulse_width_moving_average_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// pulse width moving average over WINDOW samples
// input channel: in_valid / in_stall carry one capture_width per transaction.
//   every transaction yields exactly one result transaction, in order.
// output channel: out_valid / out_stall carry accepted, last_width,
//   average_width, averaging and mass_grams.
// config channel: cfg_valid / cfg_ready write min_width; cfg_ready is always
//   high, write only while no transactions are in flight.
// throughput: one transaction per cycle unless stalled; the ring sits in a
//   one-port-read, one-port-write memory, read in the accept cycle and
//   written back in the next cycle, with a forward path for back-to-back
//   hits on the same slot.
// pipeline: ring read, sum update, divide by WINDOW in two steps, mass
//   scaling in three steps, then the output queue.
// stall: results wait in a FIFO_DEPTH-entry output queue; in_stall rises
//   only when FIFO_DEPTH transactions are in flight or queued, so a
//   FIFO_DEPTH above 8 keeps the full rate when the receiver never stalls.
// reset: synchronous, clears the sum, counters, held values and the queue;
//   min_width returns to 8000. ring contents need no clearing.

module pulse_width_moving_average_top
  import pwma_pkg::*;
#(
  parameter int WINDOW     = WINDOW_DEFAULT,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [WIDTH_W-1:0] cfg_min_width,
  // input transactions
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [WIDTH_W-1:0] capture_width,
  // result transactions
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic               accepted,
  output      logic [WIDTH_W-1:0] last_width,
  output      logic [WIDTH_W-1:0] average_width,
  output      logic               averaging,
  output      logic [MASS_W-1:0]  mass_grams
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_W = $clog2(WINDOW + 1);
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_PROD_W = 2 * SUM_W + 1;
  localparam logic [COUNT_W-1:0] FILL_FULL = COUNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0] WINDOW_SUM = SUM_W'(WINDOW);
  // floor(2^SUM_W / WINDOW): estimate is at most one below the true quotient
  localparam logic [SUM_W:0] DIV_RECIP = (SUM_W + 1)'((64'd1 << SUM_W) / WINDOW);

  // ---------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------
  logic [WIDTH_W-1:0] min_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= MIN_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_width <= cfg_min_width;
    end
  end

  // ---------------------------------------------------------------
  // flow control: everything accepted and not yet delivered
  // ---------------------------------------------------------------
  logic             in_fire;
  logic             out_fire;
  logic [OCC_W-1:0] occ;

  assign in_stall = (occ == OCC_W'(FIFO_DEPTH));
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(in_fire) - OCC_W'(out_fire);
    end
  end

  // ---------------------------------------------------------------
  // accept stage: threshold, slot selection, ring read, fill control
  // ---------------------------------------------------------------
  logic [WIDTH_W-1:0] held_raw;
  logic [WIDTH_W-1:0] held_raw_next;
  logic [COUNT_W-1:0] fill_count;
  logic [COUNT_W-1:0] fill_count_next;
  logic [SLOT_W-1:0]  oldest;
  logic [SLOT_W-1:0]  oldest_next;
  logic               avg_started;
  logic               avg_started_next;

  logic               acc0;
  logic               full0;
  logic               upd0;
  logic [SLOT_W-1:0]  slot0;
  meta_t              meta0;

  always_comb begin
    acc0  = (capture_width > min_width);
    full0 = (fill_count == FILL_FULL);
    upd0  = acc0 && full0;
    slot0 = full0 ? oldest : fill_count[SLOT_W-1:0];

    held_raw_next    = held_raw;
    fill_count_next  = fill_count;
    oldest_next      = oldest;
    avg_started_next = avg_started;
    if (acc0) begin
      held_raw_next = capture_width;
      if (full0) begin
        oldest_next      = (oldest == SLOT_LAST) ? '0 : oldest + 1'b1;
        avg_started_next = 1'b1;
      end else begin
        fill_count_next = fill_count + 1'b1;
      end
    end

    meta0.accepted   = acc0;
    meta0.last_width = held_raw_next;
    meta0.averaging  = (fill_count_next == FILL_FULL);
    meta0.avg_on     = avg_started_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_raw    <= '0;
      fill_count  <= '0;
      oldest      <= '0;
      avg_started <= 1'b0;
    end else if (in_fire) begin
      held_raw    <= held_raw_next;
      fill_count  <= fill_count_next;
      oldest      <= oldest_next;
      avg_started <= avg_started_next;
    end
  end

  // ---------------------------------------------------------------
  // sample ring memory, read at accept, written in the next cycle
  // ---------------------------------------------------------------
  logic [WIDTH_W-1:0] ring [WINDOW];
  logic [WIDTH_W-1:0] rd_data;
  logic               fwd_hit;
  logic [WIDTH_W-1:0] fwd_data;

  logic               p1_valid;
  logic               p1_upd;
  logic [SLOT_W-1:0]  p1_slot;
  logic [WIDTH_W-1:0] p1_width;
  meta_t              p1_meta;
  logic               p1_write;

  assign p1_write = p1_valid && p1_meta.accepted;

  always_ff @(posedge clk) begin
    if (p1_write) begin
      ring[p1_slot] <= p1_width;
    end
    rd_data <= ring[slot0];
  end

  // the slot being written this cycle may be the one just read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= p1_write && (p1_slot == slot0);
    end
    fwd_data <= p1_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= in_fire;
    end
    p1_upd   <= upd0;
    p1_slot  <= slot0;
    p1_width <= capture_width;
    p1_meta  <= meta0;
  end

  // ---------------------------------------------------------------
  // running sum of accepted samples: once the ring is full, drop the oldest sample; add the new one
  // ---------------------------------------------------------------
  logic [WIDTH_W-1:0] old_sample;
  logic [SUM_W-1:0]   running_sum;
  logic [SUM_W-1:0]   running_sum_next;

  logic               p2_valid;
  meta_t              p2_meta;

  always_comb begin
    old_sample       = fwd_hit ? fwd_data : rd_data;
    running_sum_next = running_sum + SUM_W'(p1_width);
    if (p1_upd) begin
      running_sum_next = running_sum_next - SUM_W'(old_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      p2_valid    <= 1'b0;
    end else begin
      if (p1_write) begin
        running_sum <= running_sum_next;
      end
      p2_valid <= p1_valid;
    end
    p2_meta <= p1_meta;
  end

  // ---------------------------------------------------------------
  // average = sum / WINDOW: reciprocal multiply, then one correction
  // ---------------------------------------------------------------
  logic [DIV_PROD_W-1:0] div_prod;

  logic                  p3_valid;
  meta_t                 p3_meta;
  logic [SUM_W-1:0]      p3_sum;
  logic [DIV_PROD_W-1:0] p3_prod;

  assign div_prod = DIV_PROD_W'(running_sum) * DIV_PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_meta <= p2_meta;
    p3_sum  <= running_sum;
    p3_prod <= div_prod;
  end

  logic [SUM_W-1:0]   quot_est;
  logic [SUM_W-1:0]   quot_rem;
  logic [SUM_W-1:0]   quot_fix;

  logic               p4_valid;
  meta_t              p4_meta;
  logic [WIDTH_W-1:0] p4_avg;

  always_comb begin
    quot_est = p3_prod[2*SUM_W-1:SUM_W];
    quot_rem = p3_sum - quot_est * WINDOW_SUM;
    quot_fix = quot_est + SUM_W'(quot_rem >= WINDOW_SUM);
  end

  // held average stays zero until the first full-window update
  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_meta <= p3_meta;
    p4_avg  <= p3_meta.avg_on ? quot_fix[WIDTH_W-1:0] : '0;
  end

  // ---------------------------------------------------------------
  // mass = avg * 10000 / 21178 in three steps
  // ---------------------------------------------------------------
  logic                   p5_valid;
  meta_t                  p5_meta;
  logic [WIDTH_W-1:0]     p5_avg;
  logic [SCALED_W-1:0]    p5_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else begin
      p5_valid <= p4_valid;
    end
    p5_meta   <= p4_meta;
    p5_avg    <= p4_avg;
    p5_scaled <= SCALED_W'(p4_avg) * SCALED_W'(MASS_NUM);
  end

  logic                   p6_valid;
  meta_t                  p6_meta;
  logic [WIDTH_W-1:0]     p6_avg;
  logic [SCALED_W-1:0]    p6_scaled;
  logic [MASS_PROD_W-1:0] p6_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_valid <= 1'b0;
    end else begin
      p6_valid <= p5_valid;
    end
    p6_meta   <= p5_meta;
    p6_avg    <= p5_avg;
    p6_scaled <= p5_scaled;
    p6_prod   <= MASS_PROD_W'(p5_scaled) * MASS_PROD_W'(MASS_RECIP);
  end

  logic [MASS_PROD_W-MASS_SHIFT-1:0] mass_est;

  logic                   p7_valid;
  meta_t                  p7_meta;
  logic [WIDTH_W-1:0]     p7_avg;
  logic [SCALED_W-1:0]    p7_scaled;
  logic [MASS_PROD_W-MASS_SHIFT-1:0] p7_quot;
  logic [SCALED_W-1:0]    p7_back;

  assign mass_est = p6_prod[MASS_PROD_W-1:MASS_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      p7_valid <= 1'b0;
    end else begin
      p7_valid <= p6_valid;
    end
    p7_meta   <= p6_meta;
    p7_avg    <= p6_avg;
    p7_scaled <= p6_scaled;
    p7_quot   <= mass_est;
    p7_back   <= SCALED_W'(mass_est) * SCALED_W'(MASS_DEN);
  end

  // estimate may be one low: fix with a single compare
  logic [SCALED_W-1:0] mass_rem;
  logic [MASS_PROD_W-MASS_SHIFT-1:0] mass_fix;
  result_t             result;

  always_comb begin
    mass_rem = p7_scaled - p7_back;
    mass_fix = p7_quot + (MASS_PROD_W - MASS_SHIFT)'(mass_rem >= SCALED_W'(MASS_DEN));

    result.accepted      = p7_meta.accepted;
    result.last_width    = p7_meta.last_width;
    result.average_width = p7_avg;
    result.averaging     = p7_meta.averaging;
    result.mass_grams    = mass_fix[MASS_W-1:0];
  end

  // ---------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------
  result_t out_data;

  pwma_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p7_valid),
    .push_data (result),
    .pop       (out_fire),
    .pop_valid (out_valid),
    .pop_data  (out_data)
  );

  assign accepted      = out_data.accepted;
  assign last_width    = out_data.last_width;
  assign average_width = out_data.average_width;
  assign averaging     = out_data.averaging;
  assign mass_grams    = out_data.mass_grams;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("in-flight count exceeds queue depth");

  a_out_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occ != '0))
    else $error("result offered with nothing in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_count <= FILL_FULL) && (oldest <= SLOT_LAST))
    else $error("fill count or oldest slot out of range");

  a_upd_full: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && p1_upd) |-> (fill_count == FILL_FULL))
    else $error("ring replacement while ring not full");

  a_fwd_src: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> ($past(p1_valid) && $past(p1_meta.accepted)))
    else $error("forward taken without a ring write");
`endif

endmodule

`default_nettype wire
